/* design/pfi_pkg.sv */
// Shared constants, codes and types of the Pareto front insert block.
`timescale 1ns / 1ps
package pfi_pkg;

    localparam int CAPACITY   = 64;
    localparam int MAX_DIMS   = 4;
    localparam int COORD_BITS = 32;
    localparam int ID_BITS    = 32;
    localparam int ADDR_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);

    localparam int IN_DATA_BITS  = 168;
    localparam int OUT_DATA_BITS = 168;

    localparam logic [2:0] DIMS_RESET = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_EQUAL     = 3'd1;
    localparam logic [2:0] ST_DOMINATED = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_HIT       = 3'd4;
    localparam logic [2:0] ST_MISS      = 3'd5;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic                       opt;
        t_coord [MAX_DIMS-1:0]      coords;
        logic [ID_BITS-1:0]         id;
    } t_entry;

endpackage

/* design/pareto_front_insert.sv */
// Top level: Pareto front table with insert and lookup over one synchronous memory.
// Items are handled one at a time: the walk reads one memory entry per cycle over the N
// stored points (N at most CAPACITY), and the next transfer is taken in the cycle after the
// result is loaded; a result stalled at the output holds off the next transfer.
// Reset (synchronous, active low) empties the table, sets the next id to one and
// dims_in_use to four; the memory itself is not cleared, the fill count guards it.
`timescale 1ns / 1ps
module pareto_front_insert (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [2:0]                         i_cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: coord_0, coord_1, coord_2, coord_3, mark_optimal, lookup_id, zero fill
    input  logic [pfi_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    // tuser: cmd
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: point_id, out_coord_0..out_coord_3, optimal_out, precision_warning, zero fill
    output logic [pfi_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    // tuser: status
    output logic [2:0]                         m_axis_tuser
);
    import pfi_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_STORE, S_DONE} t_state;

    t_state                 r_state;
    logic [2:0]             r_dims;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [CNT_BITS-1:0]    r_rd;
    logic [CNT_BITS-1:0]    r_w;
    logic                   r_pv;
    logic                   r_stop;
    logic [ID_BITS-1:0]     r_next_id;
    logic                   r_cmd;
    t_coord [MAX_DIMS-1:0]  r_pt;
    logic                   r_opt;
    logic                   r_warn;
    logic [ID_BITS-1:0]     r_lid;
    logic [2:0]             r_status;
    logic [ID_BITS-1:0]     r_pid;
    t_coord [MAX_DIMS-1:0]  r_fcoords;
    logic                   r_outopt;
    t_entry                 r_q;
    logic                   r_out_valid;
    logic [OUT_DATA_BITS-1:0] r_out_data;
    logic [2:0]             r_out_user;

    t_entry                 mem [CAPACITY];

    logic                   issue;
    logic                   greater;
    logic                   less;
    logic [2:0]             eff_dims;
    logic                   we;
    logic [ADDR_BITS-1:0]   waddr;
    t_entry                 wdata;
    logic                   room;

    // Clamp the dimension count
    always_comb begin
        if (r_dims == 3'd0) begin
            eff_dims = 3'd1;
        end else if (r_dims > 3'(MAX_DIMS)) begin
            eff_dims = 3'(MAX_DIMS);
        end else begin
            eff_dims = r_dims;
        end
    end

    // Compare the new point with the entry just read
    always_comb begin
        greater = 1'b0;
        less    = 1'b0;
        for (int k = 0; k < MAX_DIMS; k++) begin
            if (3'(k) < eff_dims) begin
                if ($signed(r_pt[k]) > $signed(r_q.coords[k])) greater = 1'b1;
                if ($signed(r_pt[k]) < $signed(r_q.coords[k])) less = 1'b1;
            end
        end
    end

    assign issue = (r_state == S_WALK) && (r_rd < r_cnt);
    assign room  = (r_w < CNT_BITS'(CAPACITY)) && (r_next_id != '0);

    // Memory write: compacting copy during the walk, new point at the end
    always_comb begin
        we    = 1'b0;
        waddr = r_w[ADDR_BITS-1:0];
        wdata = r_q;
        if (r_state == S_WALK && r_pv && r_cmd == CMD_INSERT) begin
            if (r_stop) begin
                we = 1'b1;
            end else if (greater && !less) begin
                we = 1'b0;
            end else begin
                we = 1'b1;
                if (!greater && !less) wdata.opt = r_q.opt | r_opt;
            end
        end else if (r_state == S_STORE && !r_stop && room) begin
            we         = 1'b1;
            wdata.id     = r_next_id;
            wdata.coords = r_pt;
            wdata.opt    = r_opt;
        end
    end

    // Hold the memory
    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (issue) r_q <= mem[r_rd[ADDR_BITS-1:0]];
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // Sequencer, state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dims      <= DIMS_RESET;
            r_cnt       <= '0;
            r_rd        <= '0;
            r_w         <= '0;
            r_pv        <= 1'b0;
            r_stop      <= 1'b0;
            r_next_id   <= ID_BITS'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_dims <= i_cfg_wr_data;
            // Load a result when the output register is free, drop it once taken
            if (r_state == S_DONE && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd  <= s_axis_tuser;
                        for (int k = 0; k < MAX_DIMS; k++) begin
                            r_pt[k] <= s_axis_tdata[k*32 +: COORD_BITS];
                        end
                        r_opt     <= s_axis_tdata[128];
                        r_lid     <= s_axis_tdata[160:129];
                        r_warn    <= 1'b0;
                        r_pid     <= '0;
                        r_fcoords <= '0;
                        r_outopt  <= 1'b0;
                        r_status  <= (s_axis_tuser == CMD_LOOKUP) ? ST_MISS : ST_ADDED;
                        r_rd      <= '0;
                        r_w       <= '0;
                        r_pv      <= 1'b0;
                        r_stop    <= 1'b0;
                        r_state   <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (issue) r_rd <= r_rd + 1'b1;
                    r_pv <= issue;
                    if (r_pv) begin
                        if (r_cmd == CMD_LOOKUP) begin
                            if (r_q.id == r_lid) begin
                                r_status  <= ST_HIT;
                                r_pid     <= r_q.id;
                                r_fcoords <= r_q.coords;
                                r_outopt  <= r_q.opt;
                            end
                        end else begin
                            if (we) r_w <= r_w + 1'b1;
                            if (!r_stop) begin
                                if (greater && !less) begin
                                    if (r_q.opt) begin
                                        r_warn <= 1'b1;
                                        r_opt  <= 1'b1;
                                    end
                                end else if (!greater && less) begin
                                    r_stop   <= 1'b1;
                                    r_status <= ST_DOMINATED;
                                end else if (!greater && !less) begin
                                    r_stop   <= 1'b1;
                                    r_status <= ST_EQUAL;
                                    r_pid    <= r_q.id;
                                    r_outopt <= r_q.opt | r_opt;
                                end
                            end
                        end
                    end
                    if (!issue && !r_pv) begin
                        r_state <= (r_cmd == CMD_LOOKUP) ? S_DONE : S_STORE;
                    end
                end
                S_STORE: begin
                    if (!r_stop && room) begin
                        r_cnt <= r_w + 1'b1;
                    end else begin
                        r_cnt <= r_w;
                    end
                    if (!r_stop) begin
                        r_outopt <= r_opt;
                        if (room) begin
                            r_status  <= ST_ADDED;
                            r_pid     <= r_next_id;
                            r_next_id <= r_next_id + 1'b1;
                        end else begin
                            r_status <= ST_FULL;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_user  <= r_status;
                        r_out_data  <= {6'd0, r_warn, r_outopt,
                                        32'(r_fcoords[3]), 32'(r_fcoords[2]),
                                        32'(r_fcoords[1]), 32'(r_fcoords[0]), r_pid};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Compaction never writes ahead of the read pointer
    a_w_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_w <= r_rd))
        else $error("write pointer passed read pointer");

    // Fill count stays within the memory
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_BITS'(CAPACITY))
        else $error("fill count above capacity");

    // No read data is left in flight when a new item is accepted
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_pv)
        else $error("read pending while idle");

    // A lookup never changes the table
    a_lookup_ro: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_cmd == CMD_LOOKUP) |-> !we)
        else $error("lookup wrote the memory");

endmodule
